@@ rtl/multi_slot_tick_timer_table_core_macros.svh @@
// Assertion macros for the timer table.
// MSTT_ASSERT checks that a property holds on every clock edge out of reset.
// MSTT_ASSERT_NEVER checks that a condition never holds out of reset.
`ifndef MULTI_SLOT_TICK_TIMER_TABLE_CORE_MACROS_SVH
`define MULTI_SLOT_TICK_TIMER_TABLE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MSTT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: property failed");
`define MSTT_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define MSTT_ASSERT(lbl, clk, rstn, prop)
`define MSTT_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

@@ rtl/mstt_pkg.sv @@
`default_nettype none

package mstt_pkg;

    // Table size default and result limit per tick
    localparam int SLOTS_DEFAULT = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int REP_W         = $clog2(MAX_RESULTS + 1);

    // Field codes
    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_TICK     = 1'b1;
    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_FIRE    = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_FULL  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] period_ticks;
        logic        one_shot;
        logic [7:0]  callback_tag;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic       status;
        logic [7:0] fired_tag;
        logic       last;
    } out_item_t;

    // One timer slot as stored in the table
    typedef struct packed {
        logic [31:0] remaining;
        logic [31:0] reload;
        logic        once;
        logic [7:0]  tag;
    } slot_t;

    typedef enum logic {
        OP_REGISTER,
        OP_TICK
    } op_e;

    // Classified command handed from front to back
    typedef struct packed {
        op_e   op;
        slot_t entry;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_WALK,
        B_FLUSH
    } back_state_e;

endpackage

`default_nettype wire

@@ rtl/mstt_fifo.sv @@
`default_nettype none

module mstt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic                  empty,
    output logic      [WIDTH-1:0] rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == (PW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rdata   = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + (PW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mstt_front.sv @@
`default_nettype none

module mstt_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire mstt_pkg::in_item_t item,
    output logic                  cmd_valid,
    output mstt_pkg::cmd_t        cmd,
    input  wire logic             cmd_take
);

    import mstt_pkg::*;

    localparam int CMD_DEPTH = 2;

    cmd_t cmd_in;
    logic q_empty;
    logic [$bits(cmd_t)-1:0] q_rdata;

    // Classify the item and build the slot image for a register command
    always_comb
    begin
        cmd_in.op              = (item.cmd == CMD_TICK) ? OP_TICK : OP_REGISTER;
        cmd_in.entry.remaining = item.period_ticks;
        cmd_in.entry.reload    = item.period_ticks;
        cmd_in.entry.once      = item.one_shot;
        cmd_in.entry.tag       = item.callback_tag;
    end

    mstt_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .wdata (cmd_in),
        .pop   (cmd_take),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    assign cmd_valid = !q_empty;
    assign cmd       = cmd_t'(q_rdata);

endmodule

`default_nettype wire

@@ rtl/mstt_back.sv @@
`default_nettype none

`include "multi_slot_tick_timer_table_core_macros.svh"

module mstt_back #(
    parameter int SLOTS = mstt_pkg::SLOTS_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire mstt_pkg::cmd_t cmd,
    output logic                cmd_take,
    output logic                res_push,
    input  wire logic           res_full,
    output mstt_pkg::out_item_t res_data
);

    import mstt_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    back_state_e      state_reg, state_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    wr_reg;
    logic [AW-1:0]    rd_idx_reg;
    logic [REP_W-1:0] rep_reg;
    logic             pend_valid_reg;
    logic [7:0]       pend_tag_reg;

    slot_t            slot_mem [SLOTS];
    slot_t            rdata_reg;
    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    slot_t            mem_wdata;

    slot_t            upd;
    logic             fire, report, keep, stall, last_slot, table_full;
    logic [CW-1:0]    wr_next;

    // Per-slot evaluation of the entry just read
    always_comb
    begin
        fire       = (rdata_reg.remaining == '0);
        report     = (rep_reg < REP_W'(MAX_RESULTS));
        keep       = !(fire && rdata_reg.once);
        upd        = rdata_reg;
        if (fire)
        begin
            upd.remaining = (rdata_reg.reload == '0) ? '0 : rdata_reg.reload - 32'd1;
        end
        else
        begin
            upd.remaining = rdata_reg.remaining - 32'd1;
        end
        stall      = fire && report && pend_valid_reg && res_full;
        last_slot  = (CW'(rd_idx_reg) == cnt_reg - CW'(1));
        wr_next    = wr_reg + CW'(keep);
        table_full = (cnt_reg == CW'(SLOTS));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid && cmd.op == OP_TICK && cnt_reg != '0)
                begin
                    state_next = B_WALK;
                end
            end
            B_WALK:
            begin
                if (!stall && last_slot)
                begin
                    state_next = B_FLUSH;
                end
            end
            B_FLUSH:
            begin
                if (!pend_valid_reg || !res_full)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control and datapath outputs
    always_comb
    begin
        cmd_take  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = wr_reg[AW-1:0];
        mem_wdata = upd;
        mem_re    = 1'b0;
        mem_raddr = '0;
        res_push  = 1'b0;
        res_data  = '{kind: KIND_FIRE, status: STATUS_OK, fired_tag: pend_tag_reg,
                      last: 1'b0};
        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == OP_REGISTER)
                    begin
                        if (!res_full)
                        begin
                            cmd_take  = 1'b1;
                            res_push  = 1'b1;
                            res_data  = '{kind: KIND_STATUS,
                                          status: table_full ? STATUS_FULL : STATUS_OK,
                                          fired_tag: 8'd0, last: 1'b1};
                            mem_we    = !table_full;
                            mem_waddr = cnt_reg[AW-1:0];
                            mem_wdata = cmd.entry;
                        end
                    end
                    else
                    begin
                        cmd_take = 1'b1;
                        mem_re   = (cnt_reg != '0);
                    end
                end
            end
            B_WALK:
            begin
                if (!stall)
                begin
                    mem_we   = keep;
                    res_push = fire && report && pend_valid_reg;
                    if (!last_slot)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = rd_idx_reg + AW'(1);
                    end
                end
            end
            B_FLUSH:
            begin
                res_push      = pend_valid_reg && !res_full;
                res_data.last = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            cnt_reg        <= '0;
            wr_reg         <= '0;
            rd_idx_reg     <= '0;
            rep_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (cmd_valid && cmd.op == OP_REGISTER && !res_full && !table_full)
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    if (cmd_valid && cmd.op == OP_TICK)
                    begin
                        wr_reg         <= '0;
                        rd_idx_reg     <= '0;
                        rep_reg        <= '0;
                        pend_valid_reg <= 1'b0;
                    end
                end
                B_WALK:
                begin
                    if (!stall)
                    begin
                        wr_reg <= wr_next;
                        if (fire && report)
                        begin
                            pend_valid_reg <= 1'b1;
                            rep_reg        <= rep_reg + REP_W'(1);
                        end
                        if (last_slot)
                        begin
                            cnt_reg <= wr_next;
                        end
                        else
                        begin
                            rd_idx_reg <= rd_idx_reg + AW'(1);
                        end
                    end
                end
                B_FLUSH:
                begin
                    if (!res_full)
                    begin
                        pend_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Tag of the newest reported firing, held until the next one or the walk end
    always_ff @(posedge clk)
    begin
        if (state_reg == B_WALK && !stall && fire && report)
        begin
            pend_tag_reg <= rdata_reg.tag;
        end
    end

    // Slot table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= slot_mem[mem_raddr];
        end
    end

    // Checks
    `MSTT_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= CW'(SLOTS))
    `MSTT_ASSERT(a_rep_bound, clk, rst_n, rep_reg <= REP_W'(MAX_RESULTS))
    `MSTT_ASSERT(a_wr_behind_rd, clk, rst_n, state_reg != B_WALK || wr_reg <= CW'(rd_idx_reg))
    `MSTT_ASSERT_NEVER(a_push_full, clk, rst_n, res_push && res_full)
    `MSTT_ASSERT_NEVER(a_flush_write, clk, rst_n, state_reg == B_FLUSH && mem_we)

endmodule

`default_nettype wire

@@ rtl/multi_slot_tick_timer_table_core.sv @@
// Tick timer table: up to SLOTS countdown timers, kept packed in order.
// Input channel (push/full, item): a register item (cmd 0) appends a timer
// and yields one status result (accepted or table full). A tick item (cmd 1)
// walks the occupied slots; each expired slot, max 16 per tick, yields a firing
// result with its tag, one-shots drop and the walk compacts the table.
// Result channel (empty/pop, result): oldest result shown while empty is low;
// the final result of an item has last set. A tick with no firing gives none.
// With the walker idle, a register status passes the command queue and then
// the result queue, both registered, before it shows on the result ports. The
// walker takes one item at a time: a register item in a single step, held while
// the result queue is full; a tick in a read step, then one step per occupied
// slot through the single read port of the slot table, paused while a firing
// waits on a full result queue, and a last step for the final result.
// A 2-entry command queue sits ahead of the walker and a 4-entry result queue
// after it, so input transfers continue while results wait. If the receiver
// stalls, the walker pauses once the result queue fills, then the command
// queue fills and full rises. Reset empties both queues and the table.
`default_nettype none

module multi_slot_tick_timer_table_core #(
    parameter int SLOTS = mstt_pkg::SLOTS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire mstt_pkg::in_item_t  item,
    output logic                     empty,
    input  wire logic                pop,
    output mstt_pkg::out_item_t      result
);

    import mstt_pkg::*;

    localparam int RES_DEPTH = 4;

    cmd_t      cmd;
    logic      cmd_valid, cmd_take;
    logic      res_push, res_full;
    out_item_t res_data;
    logic [$bits(out_item_t)-1:0] res_rdata;

    mstt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    mstt_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_push  (res_push),
        .res_full  (res_full),
        .res_data  (res_data)
    );

    // Result queue towards the receiver
    mstt_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (res_data),
        .pop   (pop),
        .empty (empty),
        .rdata (res_rdata)
    );

    assign result = out_item_t'(res_rdata);

endmodule

`default_nettype wire

@@ tb/sv/timer_table_checker.sv @@
`default_nettype none

module timer_table_checker #(
    parameter int SLOTS = mstt_pkg::SLOTS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire logic                full,
    input  wire mstt_pkg::in_item_t  item,
    input  wire logic                empty,
    input  wire logic                pop,
    input  wire mstt_pkg::out_item_t result,
    output int                       mismatches,
    output int                       waiting
);

    timeunit 1ns;
    timeprecision 1ps;

    import mstt_pkg::*;

    // Shadow copy of the timer table, packed in slots 0 .. live_slots-1
    logic [31:0] slot_left   [SLOTS];
    logic [31:0] slot_period [SLOTS];
    logic        slot_once   [SLOTS];
    logic [7:0]  slot_tag    [SLOTS];
    int          live_slots;

    // Results still owed by the block, oldest first
    out_item_t   owed_results[$];

    // Run statistics
    int          n_items;
    int          n_registered;
    int          n_rejected;
    int          n_fired;
    int          busiest_tick;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Apply one accepted command to the shadow table, queue what it owes
    task automatic advance_table(input in_item_t cmd_in);
        out_item_t   res;
        logic [7:0]  fired[$];
        int          idx;
        int          k;
        res = '0;
        n_items++;
        if (cmd_in.cmd == CMD_REGISTER)
        begin
            res.kind = KIND_STATUS;
            res.last = 1'b1;
            if (live_slots < SLOTS)
            begin
                slot_left[live_slots]   = cmd_in.period_ticks;
                slot_period[live_slots] = cmd_in.period_ticks;
                slot_once[live_slots]   = cmd_in.one_shot;
                slot_tag[live_slots]    = cmd_in.callback_tag;
                live_slots++;
                res.status = STATUS_OK;
                n_registered++;
            end
            else
            begin
                res.status = STATUS_FULL;
                n_rejected++;
            end
            owed_results.push_back(res);
        end
        else
        begin
            // walk the table; a removed one-shot pulls its successor into place
            idx = 0;
            while (idx < live_slots)
            begin
                if (slot_left[idx] == 32'd0)
                begin
                    if (fired.size() < MAX_RESULTS)
                        fired.push_back(slot_tag[idx]);
                    if (slot_once[idx])
                    begin
                        for (k = idx; k < live_slots - 1; k++)
                        begin
                            slot_left[k]   = slot_left[k + 1];
                            slot_period[k] = slot_period[k + 1];
                            slot_once[k]   = slot_once[k + 1];
                            slot_tag[k]    = slot_tag[k + 1];
                        end
                        live_slots--;
                        continue;
                    end
                    // zero period saturates, so it fires every tick
                    slot_left[idx] = (slot_period[idx] == 32'd0) ? 32'd0
                                                                 : slot_period[idx] - 32'd1;
                end
                else
                begin
                    slot_left[idx] = slot_left[idx] - 32'd1;
                end
                idx++;
            end
            for (k = 0; k < fired.size(); k++)
            begin
                res.kind      = KIND_FIRE;
                res.status    = STATUS_OK;
                res.fired_tag = fired[k];
                res.last      = (k == fired.size() - 1);
                owed_results.push_back(res);
            end
            n_fired += fired.size();
            if (fired.size() > busiest_tick)
                busiest_tick = fired.size();
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (owed_results.size() == 0)
        begin
            report_mismatch($sformatf("result with none owed: kind=%0d status=%0d tag=%0d last=%0d",
                                      got.kind, got.status, got.fired_tag, got.last));
        end
        else
        begin
            want = owed_results.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.fired_tag !== want.fired_tag)
                report_mismatch($sformatf("fired_tag 0x%02h, want 0x%02h",
                                          got.fired_tag, want.fired_tag));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
        end
    endtask

    task automatic print_coverage();
        $display("Ran %0d commands: %0d timers taken, %0d turned away as table full.",
                 n_items, n_registered, n_rejected);
        $display("Saw %0d firings, up to %0d on a single tick.", n_fired, busiest_tick);
    endtask

    // Watch both channels at every edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_slots   = 0;
            owed_results = {};
            n_items      = 0;
            n_registered = 0;
            n_rejected   = 0;
            n_fired      = 0;
            busiest_tick = 0;
        end
        else
        begin
            if (push && !full)
                advance_table(item);
            if (pop && !empty)
                check_result(result);
        end
        waiting = owed_results.size();
    end

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mstt_pkg::*;

    localparam int SLOTS        = SLOTS_DEFAULT;
    localparam int RANDOM_ITEMS = 435;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 400_000;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    in_item_t  item  = '0;
    logic      pop   = 1'b0;
    logic      full;
    logic      empty;
    out_item_t result;
    int        mismatches;
    int        waiting;
    int        cycle_cnt = 0;

    // Stimulus shaping
    logic      send_quiet = 1'b0;
    logic      take_quiet = 1'b0;
    int        periodic_budget = 6;
    int        reg_pct = 50;

    multi_slot_tick_timer_table_core #(
        .SLOTS (SLOTS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    timer_table_checker #(
        .SLOTS (SLOTS)
    ) u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Watchdog
    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles", cycle_cnt);
        $display("== FAIL ==");
        $finish;
    end

    function automatic in_item_t register_cmd(input logic [31:0] period, input logic once,
                                              input logic [7:0] tag);
        in_item_t it;
        it.cmd          = CMD_REGISTER;
        it.period_ticks = period;
        it.one_shot     = once;
        it.callback_tag = tag;
        return it;
    endfunction

    // Tick with junk in the fields it ignores
    function automatic in_item_t tick_cmd();
        in_item_t it;
        it.cmd          = CMD_TICK;
        it.period_ticks = $urandom;
        it.one_shot     = 1'($urandom_range(0, 1));
        it.callback_tag = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // One transfer in; push stays high straight into the next item when no gap is drawn
    task automatic send_cmd(input in_item_t it);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do @(posedge clk); while (full);
    endtask

    // Mostly one-shots with short periods; a few permanent periodic timers
    function automatic in_item_t random_cmd();
        logic        once;
        logic [31:0] period;
        if ($urandom_range(0, 99) >= reg_pct)
            return tick_cmd();
        once = 1'b1;
        if (periodic_budget > 0 && $urandom_range(0, 5) == 0)
        begin
            once = 1'b0;
            periodic_budget--;
            period = $urandom_range(1, 8);
        end
        else if ($urandom_range(0, 9) < 8)
        begin
            period = $urandom_range(0, 6);
        end
        else
        begin
            period = $urandom_range(7, 40);
        end
        return register_cmd(period, once, 8'($urandom_range(0, 255)));
    endfunction

    // Result side: random stalls, with stall-free stretches
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        wait (rst_n);
        forever
        begin
            if (taken % 32 == 0)
                take_quiet = ($urandom_range(0, 3) == 0);
            stall = take_quiet ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            taken++;
        end
    end

    initial
    begin
        int s;
        int n;
        logic [7:0] tag;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tick on an empty table gives nothing
        send_cmd(tick_cmd());
        // fill every slot with an expired timer, tags 0 and 255 among them, one periodic
        for (s = 0; s < SLOTS; s++)
        begin
            tag = (s == SLOTS - 1) ? 8'hFF : 8'(s * 17);
            send_cmd(register_cmd(32'd0, s != 5, tag));
        end
        // table full, turned away
        send_cmd(register_cmd(32'hFFFF_FFFF, 1'b1, 8'hA5));
        // all slots fire in one walk, one-shots drop out back to back
        send_cmd(tick_cmd());
        // zero-period periodic keeps firing
        send_cmd(tick_cmd());
        // longest period never comes due; period two fires on the third tick
        send_cmd(register_cmd(32'hFFFF_FFFF, 1'b1, 8'h3C));
        send_cmd(register_cmd(32'd2, 1'b1, 8'h5A));
        repeat (3) send_cmd(tick_cmd());

        // random traffic, load mix and idling redrawn per phase
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                reg_pct    = $urandom_range(25, 70);
                send_quiet = ($urandom_range(0, 3) == 0);
            end
            send_cmd(random_cmd());
        end
        push <= 1'b0;

        // drain the owed results, then give the walker time for strays
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        u_chk.print_coverage();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
